// ===== hw/rtl/dqcl_pkg.sv =====
// Shared types and constants for the dual quadrature counter with latch.
package dqcl_pkg;

	// Operation codes carried in the op field of an input beat
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERT_E1      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERT_E2      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD_MS = 2'd2;

	// Configuration data width and reset values
	localparam int CFG_DATA_W = 10;
	localparam int PERIOD_W   = 10;
	localparam logic                INVERT_RESET = 1'b1;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd20;

	// Counter width
	localparam int CNT_W = 32;

	// Input beat
	typedef struct packed {
		logic op;
		logic e1_a_edge;
		logic e1_b_edge;
		logic e2_a_edge;
		logic e2_b_edge;
		logic e1_a_level;
		logic e1_b_level;
		logic e2_a_level;
		logic e2_b_level;
	} in_t;

	// Result beat
	typedef struct packed {
		logic signed [CNT_W-1:0] window_count_e1;
		logic signed [CNT_W-1:0] window_count_e2;
		logic signed [CNT_W-1:0] running_total_e1;
		logic signed [CNT_W-1:0] running_total_e2;
		logic        [CNT_W-1:0] elapsed_ms;
	} out_t;

endpackage

// ===== hw/rtl/dual_quadrature_counter_latch.sv =====
// Top level: two x4 quadrature counters with periodic window latch and timebase.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one beat per event.
//   An edge beat (op = edge) flags which phases of each encoder changed and
//   gives the current pin levels; it updates the pulse counts and gives no
//   result. A tick beat (op = tick) latches both window counts (negated when
//   the invert register is set), clears the pulse counts, adds the windows to
//   the running totals and advances the millisecond timebase by the period.
//   Each tick gives one beat on the output channel (out_valid / out_stall /
//   out_item); edge beats give none.
//   A tick's result passes the input register, then the result register.
//   Throughput: one beat per cycle, unless a tick waits on an unread result.
//   Configuration: cfg_we with cfg_index / cfg_data writes a register; write
//   only while the block is idle. Indexes beyond the list are ignored.
//   Reset: counts, totals and timebase clear to zero; both invert bits set;
//   period is 20 ms. While the receiver stalls, the held result stays put and
//   edge beats keep flowing; a second tick waits in the input register, and
//   only then does in_stall rise.
module dual_quadrature_counter_latch (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  dqcl_pkg::in_t                         in_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output dqcl_pkg::out_t                        out_item,
	input  logic                                  cfg_we,
	input  logic [dqcl_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dqcl_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Configuration registers
	logic                              invert_e1_q;
	logic                              invert_e2_q;
	logic [dqcl_pkg::PERIOD_W-1:0]     period_q;

	// Input register
	logic                              valid_s1;
	dqcl_pkg::in_t                     item_s1;

	// Counter state
	logic [dqcl_pkg::CNT_W-1:0]        pulse_e1_q;
	logic [dqcl_pkg::CNT_W-1:0]        pulse_e2_q;
	logic [dqcl_pkg::CNT_W-1:0]        total_e1_q;
	logic [dqcl_pkg::CNT_W-1:0]        total_e2_q;
	logic [dqcl_pkg::CNT_W-1:0]        ms_q;

	// Result register
	logic                              out_valid_q;
	dqcl_pkg::out_t                    out_q;

	// Datapath
	logic [dqcl_pkg::CNT_W-1:0]        pulse_e1_next;
	logic [dqcl_pkg::CNT_W-1:0]        pulse_e2_next;
	logic [dqcl_pkg::CNT_W-1:0]        window_e1;
	logic [dqcl_pkg::CNT_W-1:0]        window_e2;
	logic [dqcl_pkg::CNT_W-1:0]        total_e1_next;
	logic [dqcl_pkg::CNT_W-1:0]        total_e2_next;
	logic [dqcl_pkg::CNT_W-1:0]        ms_next;
	logic                              tick_s1;
	logic                              blocked_s1;
	logic                              fire_s1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_e1_q <= dqcl_pkg::INVERT_RESET;
			invert_e2_q <= dqcl_pkg::INVERT_RESET;
			period_q    <= dqcl_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dqcl_pkg::REG_INVERT_E1:      invert_e1_q <= cfg_data[0];
				dqcl_pkg::REG_INVERT_E2:      invert_e2_q <= cfg_data[0];
				dqcl_pkg::REG_TICK_PERIOD_MS: period_q    <= cfg_data[dqcl_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold a tick in the input register while a result waits unread
	assign tick_s1    = item_s1.op == dqcl_pkg::OP_TICK;
	assign blocked_s1 = valid_s1 && tick_s1 && out_valid_q && out_stall;
	assign fire_s1    = valid_s1 && !blocked_s1;
	assign in_stall   = blocked_s1;

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// Decode edges for each encoder
	dqcl_quad_step u_step_e1 (
		.acc      (pulse_e1_q),
		.a_edge   (item_s1.e1_a_edge),
		.b_edge   (item_s1.e1_b_edge),
		.a_level  (item_s1.e1_a_level),
		.b_level  (item_s1.e1_b_level),
		.acc_next (pulse_e1_next)
	);

	dqcl_quad_step u_step_e2 (
		.acc      (pulse_e2_q),
		.a_edge   (item_s1.e2_a_edge),
		.b_edge   (item_s1.e2_b_edge),
		.a_level  (item_s1.e2_a_level),
		.b_level  (item_s1.e2_b_level),
		.acc_next (pulse_e2_next)
	);

	// Latch windows, optionally negated, and advance totals and timebase
	assign window_e1     = invert_e1_q ? (-pulse_e1_q) : pulse_e1_q;
	assign window_e2     = invert_e2_q ? (-pulse_e2_q) : pulse_e2_q;
	assign total_e1_next = total_e1_q + window_e1;
	assign total_e2_next = total_e2_q + window_e2;
	assign ms_next       = ms_q + {{(dqcl_pkg::CNT_W-dqcl_pkg::PERIOD_W){1'b0}}, period_q};

	// Update counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_e1_q <= '0;
			pulse_e2_q <= '0;
			total_e1_q <= '0;
			total_e2_q <= '0;
			ms_q       <= '0;
		end else if (fire_s1) begin
			if (tick_s1) begin
				pulse_e1_q <= '0;
				pulse_e2_q <= '0;
				total_e1_q <= total_e1_next;
				total_e2_q <= total_e2_next;
				ms_q       <= ms_next;
			end else begin
				pulse_e1_q <= pulse_e1_next;
				pulse_e2_q <= pulse_e2_next;
			end
		end
	end

	// Result register: load on a tick, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && tick_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && tick_s1) begin
			out_q.window_count_e1  <= window_e1;
			out_q.window_count_e2  <= window_e2;
			out_q.running_total_e1 <= total_e1_next;
			out_q.running_total_e2 <= total_e2_next;
			out_q.elapsed_ms       <= ms_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== hw/rtl/dqcl_quad_step.sv =====
// One encoder's x4 decode: applies the A and B edge rules to a pulse count.
module dqcl_quad_step (
	input  logic [dqcl_pkg::CNT_W-1:0] acc,
	input  logic                       a_edge,
	input  logic                       b_edge,
	input  logic                       a_level,
	input  logic                       b_level,
	output logic [dqcl_pkg::CNT_W-1:0] acc_next
);

	logic signed [2:0] a_delta;
	logic signed [2:0] b_delta;
	logic signed [2:0] delta;

	// A edge: up with B high, down with B low
	always_comb begin
		if (!a_edge) begin
			a_delta = 3'sd0;
		end else if (b_level) begin
			a_delta = 3'sd1;
		end else begin
			a_delta = -3'sd1;
		end
	end

	// B edge: down with A high, up with A low
	always_comb begin
		if (!b_edge) begin
			b_delta = 3'sd0;
		end else if (a_level) begin
			b_delta = -3'sd1;
		end else begin
			b_delta = 3'sd1;
		end
	end

	assign delta = a_delta + b_delta;

	// Add the sign-extended net change, wrapping
	assign acc_next = acc + {{(dqcl_pkg::CNT_W-3){delta[2]}}, delta};

endmodule
